// ===== sv/tristate_remote_code_sender_defines.svh =====
// Assertion macros for the tri-state code sender RTL.
`ifndef TRISTATE_REMOTE_CODE_SENDER_DEFINES_SVH
`define TRISTATE_REMOTE_CODE_SENDER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define RCS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen at a clock edge outside reset.
`define RCS_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RCS_ASSERT(name, prop, msg)
`define RCS_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// ===== sv/rcs_pkg.sv =====
// Types, constants and functions shared by the tri-state code sender.
package rcs_pkg;

  localparam int unsigned DATA_W         = 20;
  localparam int unsigned POW_W          = 26;
  localparam int unsigned TRIT_COUNT_DEF = 12;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 6;

  // Register reset values.
  localparam logic [3:0] REPEAT_RESET = 4'd8;
  localparam logic [2:0] LONG_RESET   = 3'd3;
  localparam logic [5:0] GAP_RESET    = 6'd31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPEAT_COUNT = 2'd0,
    REG_LONG_UNITS   = 2'd1,
    REG_GAP_UNITS    = 2'd2
  } rcs_reg_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } rcs_op_e;

  typedef enum logic [1:0] {
    TRIT_ZERO = 2'd0,
    TRIT_ONE  = 2'd1,
    TRIT_TWO  = 2'd2
  } rcs_trit_e;

  typedef struct packed {
    logic [3:0] repeat_count;
    logic [2:0] long_units;
    logic [5:0] gap_units;
  } rcs_cfg_t;

  typedef struct packed {
    logic              operation;
    logic [DATA_W-1:0] data_value;
  } rcs_item_t;

  // Power of three for elaboration-time constants.
  function automatic longint unsigned rcs_pow3_c(input int unsigned n);
    longint unsigned p;
    p = 1;
    for (int unsigned i = 0; i < n; i++) begin
      p = p * 3;
    end
    return p;
  endfunction

  // Power of three for a digit position, as a constant table.
  function automatic logic [POW_W-1:0] rcs_pow3(input logic [3:0] pos);
    logic [POW_W-1:0] p;
    case (pos)
      4'd0:    p = 26'd1;
      4'd1:    p = 26'd3;
      4'd2:    p = 26'd9;
      4'd3:    p = 26'd27;
      4'd4:    p = 26'd81;
      4'd5:    p = 26'd243;
      4'd6:    p = 26'd729;
      4'd7:    p = 26'd2187;
      4'd8:    p = 26'd6561;
      4'd9:    p = 26'd19683;
      4'd10:   p = 26'd59049;
      4'd11:   p = 26'd177147;
      4'd12:   p = 26'd531441;
      4'd13:   p = 26'd1594323;
      4'd14:   p = 26'd4782969;
      4'd15:   p = 26'd14348907;
      default: p = 26'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== sv/rcs_interfaces.sv =====
// Handshake channels of the tri-state code sender: items, results and configuration.
interface rcs_item_if;
  import rcs_pkg::*;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [DATA_W-1:0] data_value;
  modport source (output valid, output operation, output data_value, input ready);
  modport sink   (input valid, input operation, input data_value, output ready);
endinterface

interface rcs_result_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic last;
  modport source (output valid, output line_level, output busy_res, output last,
                  input ready);
  modport sink   (input valid, input line_level, input busy_res, input last,
                  output ready);
endinterface

interface rcs_cfg_if;
  import rcs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/rcs_in_stage.sv =====
// Input register of the code sender, with the reciprocal product for the start value.
module rcs_in_stage #(
  parameter int unsigned  TritCount = rcs_pkg::TRIT_COUNT_DEF,
  localparam longint unsigned ModP  = rcs_pkg::rcs_pow3_c(TritCount),
  localparam longint unsigned RecipM = (longint'(1) << rcs_pkg::DATA_W) / ModP,
  localparam int unsigned QuotW     = (RecipM > 0) ? $clog2(RecipM + 1) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  rcs_item_if.sink            item_i,
  input  logic                take_i,
  output logic                valid_o,
  output rcs_pkg::rcs_item_t  item_o,
  output logic [QuotW-1:0]    quot_o
);
  import rcs_pkg::*;

  logic                    valid_q;
  rcs_item_t               item_q;
  logic [QuotW-1:0]        quot_q;
  logic [DATA_W+QuotW-1:0] prod;
  logic [QuotW-1:0]        quot_d;

  // The register is free when empty or when its word moves on this cycle.
  assign item_i.ready = !valid_q || take_i;

  // Estimate of the value divided by 3^TritCount, low by at most one.
  assign prod   = (DATA_W + QuotW)'(item_i.data_value) * (DATA_W + QuotW)'(RecipM);
  assign quot_d = prod[DATA_W +: QuotW];

  // Valid flag of the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (item_i.valid && item_i.ready) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload of the input register.
  always_ff @(posedge clk_i) begin
    if (item_i.valid && item_i.ready) begin
      item_q <= '{operation: item_i.operation, data_value: item_i.data_value};
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign quot_o  = quot_q;

endmodule

// ===== sv/rcs_tx_core.sv =====
// Transmission state, digit selection, segment timing and result register.
`include "tristate_remote_code_sender_defines.svh"

module rcs_tx_core #(
  parameter int unsigned  TritCount = rcs_pkg::TRIT_COUNT_DEF,
  localparam longint unsigned ModP  = rcs_pkg::rcs_pow3_c(TritCount),
  localparam longint unsigned RecipM = (longint'(1) << rcs_pkg::DATA_W) / ModP,
  localparam int unsigned QuotW     = (RecipM > 0) ? $clog2(RecipM + 1) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcs_pkg::rcs_cfg_t  cfg_i,
  input  logic               valid_i,
  input  rcs_pkg::rcs_item_t item_i,
  input  logic [QuotW-1:0]   quot_i,
  output logic               take_o,
  rcs_result_if.source       result_o
);
  import rcs_pkg::*;

  localparam int unsigned PowBits = $clog2(ModP);
  localparam int unsigned RemW    = (PowBits < DATA_W) ? PowBits : DATA_W;
  localparam int unsigned IdxW    = (TritCount > 1) ? $clog2(TritCount) : 1;
  localparam logic [IdxW-1:0]   LastIdx  = IdxW'(TritCount - 1);
  localparam logic [DATA_W-1:0] ModPLow  = DATA_W'(ModP);
  localparam logic [POW_W-1:0]  ModPFull = POW_W'(ModP);

  // Transmission state.
  logic [RemW-1:0] rem_full_q, rem_full_d;
  logic [RemW-1:0] rem_q, rem_d;
  logic [IdxW-1:0] trit_index_q, trit_index_d;
  logic [1:0]      segment_phase_q, segment_phase_d;
  logic [5:0]      unit_counter_q, unit_counter_d;
  logic [3:0]      frames_left_q, frames_left_d;
  logic            sending_sync_q, sending_sync_d;
  logic            active_q, active_d;

  // Result register.
  logic out_valid_q;
  logic line_level_q, busy_q, last_q;
  logic res_level, res_busy, res_last;

  logic [DATA_W-1:0] qp, r1, r2;
  logic [RemW-1:0]   load_rem;
  logic [3:0]        pos;
  logic [POW_W-1:0]  pw, pw2, rem_ext, sub;
  rcs_trit_e         digit;
  logic [RemW-1:0]   rem_step;
  logic [5:0]        long_len, gap_len, seg_len, cnt_inc;
  logic              seg_level, is_long;

  assign take_o = valid_i && (!out_valid_q || result_o.ready);

  // Start value reduced modulo 3^TritCount: one correction after the estimate.
  assign qp       = DATA_W'(DATA_W'(quot_i) * ModPLow);
  assign r1       = item_i.data_value - qp;
  assign r2       = (POW_W'(r1) >= ModPFull) ? (r1 - ModPLow) : r1;
  assign load_rem = RemW'(r2);

  // Current digit, most significant first, from the running remainder.
  assign pos     = 4'(TritCount - 1) - 4'(trit_index_q);
  assign pw      = rcs_pow3(pos);
  assign pw2     = pw << 1;
  assign rem_ext = POW_W'(rem_q);

  always_comb begin
    if (rem_ext >= pw2) begin
      digit = TRIT_TWO;
      sub   = pw2;
    end else if (rem_ext >= pw) begin
      digit = TRIT_ONE;
      sub   = pw;
    end else begin
      digit = TRIT_ZERO;
      sub   = '0;
    end
  end

  assign rem_step = rem_q - RemW'(sub);

  // Segment lengths; a zero setting counts as one unit.
  assign long_len = (cfg_i.long_units == 3'd0) ? 6'd1 : 6'(cfg_i.long_units);
  assign gap_len  = (cfg_i.gap_units == 6'd0) ? 6'd1 : cfg_i.gap_units;

  // Level and length of the segment now on the line.
  always_comb begin
    is_long = 1'b0;
    if (sending_sync_q) begin
      seg_level = (segment_phase_q == 2'd0);
      seg_len   = (segment_phase_q == 2'd0) ? 6'd1 : gap_len;
    end else begin
      seg_level = !segment_phase_q[0];
      case (digit)
        TRIT_ZERO: is_long = segment_phase_q[0];
        TRIT_ONE:  is_long = !segment_phase_q[0];
        TRIT_TWO:  is_long = (segment_phase_q == 2'd1) || (segment_phase_q == 2'd2);
        default:   is_long = 1'b0;
      endcase
      seg_len = is_long ? long_len : 6'd1;
    end
  end

  assign cnt_inc = unit_counter_q + 6'd1;

  // Next state and result for the word leaving the input register.
  always_comb begin
    rem_full_d      = rem_full_q;
    rem_d           = rem_q;
    trit_index_d    = trit_index_q;
    segment_phase_d = segment_phase_q;
    unit_counter_d  = unit_counter_q;
    frames_left_d   = frames_left_q;
    sending_sync_d  = sending_sync_q;
    active_d        = active_q;
    res_level       = 1'b0;
    res_busy        = active_q;
    res_last        = 1'b0;
    if (take_o) begin
      case (rcs_op_e'(item_i.operation))
        OP_START: begin
          // A start while a transmission runs is dropped.
          res_busy = 1'b1;
          if (!active_q) begin
            rem_full_d      = load_rem;
            rem_d           = load_rem;
            trit_index_d    = '0;
            segment_phase_d = 2'd0;
            unit_counter_d  = 6'd0;
            sending_sync_d  = 1'b0;
            frames_left_d   = (cfg_i.repeat_count == 4'd0) ? 4'd1 : cfg_i.repeat_count;
            active_d        = 1'b1;
          end
        end
        OP_TICK: begin
          if (active_q) begin
            res_level = seg_level;
            if (cnt_inc >= seg_len) begin
              unit_counter_d = 6'd0;
              if (sending_sync_q) begin
                if (segment_phase_q == 2'd0) begin
                  segment_phase_d = 2'd1;
                end else begin
                  // End of the frame: rewind to the first digit.
                  segment_phase_d = 2'd0;
                  sending_sync_d  = 1'b0;
                  trit_index_d    = '0;
                  rem_d           = rem_full_q;
                  frames_left_d   = frames_left_q - 4'd1;
                  if (frames_left_q == 4'd1) begin
                    active_d = 1'b0;
                    res_last = 1'b1;
                  end
                end
              end else if (segment_phase_q != 2'd3) begin
                segment_phase_d = segment_phase_q + 2'd1;
              end else begin
                segment_phase_d = 2'd0;
                rem_d           = rem_step;
                if (trit_index_q == LastIdx) begin
                  trit_index_d   = '0;
                  sending_sync_d = 1'b1;
                end else begin
                  trit_index_d = trit_index_q + IdxW'(1);
                end
              end
            end else begin
              unit_counter_d = cnt_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trit_index_q    <= '0;
      segment_phase_q <= 2'd0;
      unit_counter_q  <= 6'd0;
      frames_left_q   <= 4'd0;
      sending_sync_q  <= 1'b0;
      active_q        <= 1'b0;
    end else begin
      trit_index_q    <= trit_index_d;
      segment_phase_q <= segment_phase_d;
      unit_counter_q  <= unit_counter_d;
      frames_left_q   <= frames_left_d;
      sending_sync_q  <= sending_sync_d;
      active_q        <= active_d;
    end
  end

  // Digit remainders.
  always_ff @(posedge clk_i) begin
    rem_full_q <= rem_full_d;
    rem_q      <= rem_d;
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      line_level_q <= res_level;
      busy_q       <= res_busy;
      last_q       <= res_last;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.line_level = line_level_q;
  assign result_o.busy_res   = busy_q;
  assign result_o.last       = last_q;

  // A running transmission always has at least one frame to go.
  `RCS_ASSERT(a_frames_while_active, active_q |-> frames_left_q != 4'd0, "active with no frames left")
  // The digit index never passes the last digit.
  `RCS_ASSERT_NEVER(a_index_range, trit_index_q > LastIdx, "digit index out of range")
  // A final or idle result leaves the block idle until another word moves.
  `RCS_ASSERT(a_last_idle, out_valid_q && (last_q || !busy_q) |-> !active_q, "busy after final unit")
  // A transmission begins at the first segment of the first digit.
  `RCS_ASSERT(a_start_clean, $rose(active_q) |-> (trit_index_q == '0) && (segment_phase_q == 2'd0) && (unit_counter_q == 6'd0) && !sending_sync_q, "start state not clean")
  // The working remainder only shrinks within a frame.
  `RCS_ASSERT(a_rem_bound, active_q |-> rem_q <= rem_full_q, "remainder above loaded value")

endmodule

// ===== sv/tristate_remote_code_sender.sv =====
// Top level of the tri-state remote code sender: configuration registers and datapath.
//
//   Channel   Dir  Payload                          Handshake
//   item_i    in   operation, data_value            valid/ready
//   result_o  out  line_level, busy_res, last       valid/ready
//   cfg_i     in   index, data                      valid/ready (ready held high)
//
// One word is accepted per clock cycle while the result is not stalled. A word is held in the
// input register and its result is loaded into the result register when the word moves on,
// where the result can be taken; digit selection and segment timing sit between the two.
// Reset clears all control state and sets eight frames, long segments of three units and a
// gap of thirty-one units; no clearing pass follows.
// A stalled result holds the result register; item ready falls once the input register is full.
module tristate_remote_code_sender #(
  parameter int unsigned TritCount = rcs_pkg::TRIT_COUNT_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rcs_item_if.sink     item_i,
  rcs_result_if.source result_o,
  rcs_cfg_if.sink      cfg_i
);
  import rcs_pkg::*;

  localparam longint unsigned ModP   = rcs_pow3_c(TritCount);
  localparam longint unsigned RecipM = (longint'(1) << DATA_W) / ModP;
  localparam int unsigned     QuotW  = (RecipM > 0) ? $clog2(RecipM + 1) : 1;

  logic [3:0]       repeat_count_q;
  logic [2:0]       long_units_q;
  logic [5:0]       gap_units_q;
  rcs_cfg_t         cfg;
  logic             s1_valid;
  rcs_item_t        s1_item;
  logic [QuotW-1:0] s1_quot;
  logic             s1_take;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_count_q <= REPEAT_RESET;
      long_units_q   <= LONG_RESET;
      gap_units_q    <= GAP_RESET;
    end else if (cfg_i.valid) begin
      case (rcs_reg_e'(cfg_i.index))
        REG_REPEAT_COUNT: repeat_count_q <= cfg_i.data[3:0];
        REG_LONG_UNITS:   long_units_q   <= cfg_i.data[2:0];
        REG_GAP_UNITS:    gap_units_q    <= cfg_i.data[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{repeat_count: repeat_count_q, long_units: long_units_q,
                 gap_units: gap_units_q};

  rcs_in_stage #(
    .TritCount (TritCount)
  ) u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_i),
    .take_i  (s1_take),
    .valid_o (s1_valid),
    .item_o  (s1_item),
    .quot_o  (s1_quot)
  );

  rcs_tx_core #(
    .TritCount (TritCount)
  ) u_tx_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s1_valid),
    .item_i   (s1_item),
    .quot_i   (s1_quot),
    .take_o   (s1_take),
    .result_o (result_o)
  );

endmodule
